### sv/txtcg_pkg.sv
// Shared types and constants for the text-RAM and character-generator window port.
// Holds the decoded access command that travels from the front end to the back end.
// No dependencies.
package txtcg_pkg;

    localparam int TEXT_BYTES         = 16384;
    localparam int CELL_COUNT         = 4096;
    localparam int FONT_ADDR_BITS_DEF = 19;

    localparam int ROW_W   = $clog2(TEXT_BYTES / 2);
    localparam int CELL_W  = $clog2(CELL_COUNT);
    localparam int BASE_W  = 19;
    localparam int OFF_W   = 4;
    localparam int ADDR_W  = 15;
    localparam int DATA_W  = 16;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 48;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [ADDR_W-1:0] CODE_SEAM  = 15'h1FFF;
    localparam logic [ADDR_W-1:0] ATTR_START = 15'h2000;
    localparam logic [ADDR_W-1:0] PROT_START = 15'h3FE0;
    localparam logic [ADDR_W-1:0] ATTR_LAST  = 15'h3FFF;
    localparam logic [ADDR_W-1:0] FONT_START = 15'h4000;
    localparam logic [ADDR_W-1:0] FONT_LAST  = 15'h4FFF;
    localparam logic [ADDR_W-1:0] WIN_END    = 15'h5000;

    localparam logic [1:0] MARK_CODE      = 2'd1;
    localparam logic [1:0] MARK_BOTH      = 2'd3;
    localparam logic [1:0] DISP_CODE      = 2'd1;
    localparam logic [1:0] DISP_ATTR_WORD = 2'd3;

    typedef enum logic [1:0] {
        ACT_READ_BYTE  = 2'd0,
        ACT_READ_WORD  = 2'd1,
        ACT_WRITE_BYTE = 2'd2,
        ACT_WRITE_WORD = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_LOW_BASE    = 2'd0,
        REG_HIGH_BASE   = 2'd1,
        REG_FONT_WE     = 2'd2,
        REG_PROTECT_OPEN = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        SRC_ZERO   = 3'd0,
        SRC_EVEN   = 3'd1,
        SRC_ODD    = 3'd2,
        SRC_FONT_A = 3'd3,
        SRC_FONT_B = 3'd4
    } t_src;

    typedef struct packed {
        logic [ROW_W-1:0]  even_row;
        logic [ROW_W-1:0]  odd_row;
        logic              even_we;
        logic              odd_we;
        logic [7:0]        even_wdata;
        logic [7:0]        odd_wdata;
        logic              font_we;
        logic [7:0]        font_wdata;
        logic              font_a_high;
        logic [OFF_W-1:0]  font_a_off;
        logic              font_b_high;
        logic [OFF_W-1:0]  font_b_off;
        t_src              lo_src;
        t_src              hi_src;
        logic [CELL_W-1:0] mark_a_index;
        logic [1:0]        mark_a_bits;
        logic [CELL_W-1:0] mark_b_index;
        logic [1:0]        mark_b_bits;
        logic [1:0]        display_flags;
    } t_cmd;

endpackage

### sv/txtcg_front.sv
// Front end of the window port: accepts an access beat and decodes it into a command.
// Depends on txtcg_pkg.
module txtcg_front
    import txtcg_pkg::*;
(
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [IN_W-1:0] i_s_tdata,
    input  logic            i_clearing,
    input  logic            i_q_full,
    input  logic            i_font_we,
    input  logic            i_protect_open,
    output logic            o_push,
    output t_cmd            o_cmd
);

    t_action           w_act;
    logic [ADDR_W-1:0] w_addr;
    logic [DATA_W-1:0] w_wd;
    logic              w_odd;
    logic [ADDR_W-2:0] w_sum;
    logic [ADDR_W-1:0] w_t;
    logic [OFF_W-1:0]  w_off;
    logic              w_a_ok;
    logic              w_t_ok;

    assign o_s_tready = !i_clearing && !i_q_full;
    assign o_push     = i_s_tvalid && o_s_tready;

    always_comb begin
        w_act  = t_action'(i_s_tdata[1:0]);
        w_addr = i_s_tdata[16:2];
        w_wd   = i_s_tdata[32:17];
        w_odd  = w_addr[0];
        w_sum  = w_addr[ADDR_W-1:1] + (ADDR_W-1)'(w_addr[0]);
        w_t    = w_addr + ADDR_W'(w_addr[0]);
        w_off  = w_addr[OFF_W:1];
        w_a_ok = (w_addr < PROT_START) || !w_addr[1] || i_protect_open;
        w_t_ok = (w_t < PROT_START) || !w_t[1] || i_protect_open;

        o_cmd          = '0;
        o_cmd.even_row = w_sum[ROW_W-1:0];
        o_cmd.odd_row  = w_addr[ROW_W:1];
        o_cmd.lo_src   = SRC_ZERO;
        o_cmd.hi_src   = SRC_ZERO;

        unique case (w_act)
            ACT_READ_BYTE: begin
                if (w_addr < FONT_START) begin
                    o_cmd.lo_src = w_odd ? SRC_ODD : SRC_EVEN;
                end else if (w_addr < WIN_END) begin
                    o_cmd.lo_src      = SRC_FONT_A;
                    o_cmd.font_a_high = w_odd;
                    o_cmd.font_a_off  = w_off;
                end
            end
            ACT_READ_WORD: begin
                if (w_addr < ATTR_LAST) begin
                    o_cmd.lo_src = w_odd ? SRC_ODD : SRC_EVEN;
                    o_cmd.hi_src = w_odd ? SRC_EVEN : SRC_ODD;
                end else if (w_addr == ATTR_LAST) begin
                    o_cmd.lo_src      = SRC_ODD;
                    o_cmd.hi_src      = SRC_FONT_A;
                    o_cmd.font_a_high = 1'b0;
                    o_cmd.font_a_off  = '0;
                end else if (w_addr < FONT_LAST) begin
                    o_cmd.lo_src      = SRC_FONT_A;
                    o_cmd.hi_src      = SRC_FONT_B;
                    o_cmd.font_a_high = w_odd;
                    o_cmd.font_a_off  = w_off;
                    o_cmd.font_b_high = !w_odd;
                    o_cmd.font_b_off  = w_odd ? w_sum[OFF_W-1:0] : w_off;
                end else if (w_addr == FONT_LAST) begin
                    o_cmd.lo_src      = SRC_FONT_A;
                    o_cmd.font_a_high = 1'b1;
                    o_cmd.font_a_off  = w_off;
                end
            end
            ACT_WRITE_BYTE: begin
                if (w_addr < ATTR_START) begin
                    o_cmd.even_we       = !w_odd;
                    o_cmd.odd_we        = w_odd;
                    o_cmd.even_wdata    = w_wd[7:0];
                    o_cmd.odd_wdata     = w_wd[7:0];
                    o_cmd.mark_a_index  = w_addr[CELL_W:1];
                    o_cmd.mark_a_bits   = MARK_CODE;
                    o_cmd.display_flags = DISP_CODE;
                end else if (w_addr < FONT_START) begin
                    if (!w_odd && w_a_ok) begin
                        o_cmd.even_we       = 1'b1;
                        o_cmd.even_wdata    = w_wd[7:0];
                        o_cmd.mark_a_index  = w_addr[CELL_W:1];
                        o_cmd.mark_a_bits   = MARK_BOTH;
                        o_cmd.display_flags = DISP_CODE;
                    end
                end else if (w_addr < WIN_END) begin
                    if (w_odd && i_font_we) begin
                        o_cmd.font_we     = 1'b1;
                        o_cmd.font_wdata  = w_wd[7:0];
                        o_cmd.font_a_high = 1'b1;
                        o_cmd.font_a_off  = w_off;
                    end
                end
            end
            ACT_WRITE_WORD: begin
                if (w_addr <= CODE_SEAM) begin
                    o_cmd.even_we       = 1'b1;
                    o_cmd.odd_we        = 1'b1;
                    o_cmd.even_wdata    = w_odd ? w_wd[15:8] : w_wd[7:0];
                    o_cmd.odd_wdata     = w_odd ? w_wd[7:0] : w_wd[15:8];
                    o_cmd.mark_a_index  = w_addr[CELL_W:1];
                    o_cmd.mark_a_bits   = MARK_CODE;
                    o_cmd.display_flags = DISP_CODE;
                    if (w_odd) begin
                        o_cmd.mark_b_index = w_sum[CELL_W-1:0];
                        o_cmd.mark_b_bits  = (w_addr == CODE_SEAM) ? MARK_BOTH : MARK_CODE;
                    end
                end else if (w_addr < ATTR_LAST) begin
                    if (w_t_ok) begin
                        o_cmd.even_we       = 1'b1;
                        o_cmd.even_wdata    = w_odd ? w_wd[15:8] : w_wd[7:0];
                        o_cmd.mark_a_index  = w_t[CELL_W:1];
                        o_cmd.mark_a_bits   = MARK_BOTH;
                        o_cmd.display_flags = DISP_ATTR_WORD;
                    end
                end else if (w_addr < WIN_END) begin
                    if (i_font_we) begin
                        o_cmd.font_we     = 1'b1;
                        o_cmd.font_wdata  = w_odd ? w_wd[7:0] : w_wd[15:8];
                        o_cmd.font_a_high = 1'b1;
                        o_cmd.font_a_off  = w_off;
                    end
                end
            end
            default: begin
                o_cmd.lo_src = SRC_ZERO;
            end
        endcase
    end

endmodule

### sv/txtcg_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on txtcg_pkg.
module txtcg_queue
    import txtcg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_cmd               i_cmd,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_full,
    output logic [Q_CNT_W-1:0] o_count,
    output t_cmd               o_cmd
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_count = r_count;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

### sv/txtcg_back.sv
// Back end of the window port: text and font stores, read assembly and result register.
// Runs the clearing pass of the text store after reset. Depends on txtcg_pkg.
module txtcg_back
    import txtcg_pkg::*;
#(
    parameter int FONT_ADDR_BITS = FONT_ADDR_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_cmd              i_q_cmd,
    output logic              o_pop,
    input  logic [BASE_W-1:0] i_low_base,
    input  logic [BASE_W-1:0] i_high_base,
    output logic              o_clearing,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [OUT_W-1:0]  o_tdata
);

    localparam int FONT_DEPTH = 2 ** FONT_ADDR_BITS;

    logic [7:0] r_text_even [TEXT_BYTES / 2];
    logic [7:0] r_text_odd  [TEXT_BYTES / 2];
    logic [7:0] r_font      [FONT_DEPTH];

    logic [7:0]         r_even_q;
    logic [7:0]         r_odd_q;
    logic [7:0]         r_font_qa;
    logic [7:0]         r_font_qb;
    logic               r_s1_valid;
    t_cmd               r_s1_cmd;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_tdata;
    logic               r_clearing;
    logic [ROW_W-1:0]   r_clr_row;

    logic                      w_out_free;
    logic                      w_s1_go;
    logic [BASE_W:0]           w_sum_a;
    logic [BASE_W:0]           w_sum_b;
    logic [FONT_ADDR_BITS-1:0] w_font_addr_a;
    logic [FONT_ADDR_BITS-1:0] w_font_addr_b;
    logic [7:0]                w_lo;
    logic [7:0]                w_hi;

    function automatic logic [7:0] pick(input t_src src, input logic [7:0] even_q,
                                        input logic [7:0] odd_q, input logic [7:0] fa,
                                        input logic [7:0] fb);
        case (src)
            SRC_EVEN:   pick = even_q;
            SRC_ODD:    pick = odd_q;
            SRC_FONT_A: pick = fa;
            SRC_FONT_B: pick = fb;
            default:    pick = 8'h00;
        endcase
    endfunction

    assign w_out_free = !r_out_valid || i_tready;
    assign w_s1_go    = r_s1_valid && w_out_free;
    assign o_pop      = i_q_valid && !r_clearing && (!r_s1_valid || w_out_free);
    assign o_clearing = r_clearing;
    assign o_tvalid   = r_out_valid;
    assign o_tdata    = r_out_tdata;

    always_comb begin
        w_sum_a = {1'b0, i_q_cmd.font_a_high ? i_high_base : i_low_base}
                  + (BASE_W + 1)'(i_q_cmd.font_a_off);
        w_sum_b = {1'b0, i_q_cmd.font_b_high ? i_high_base : i_low_base}
                  + (BASE_W + 1)'(i_q_cmd.font_b_off);
        w_font_addr_a = w_sum_a[FONT_ADDR_BITS-1:0];
        w_font_addr_b = w_sum_b[FONT_ADDR_BITS-1:0];
        w_lo = pick(r_s1_cmd.lo_src, r_even_q, r_odd_q, r_font_qa, r_font_qb);
        w_hi = pick(r_s1_cmd.hi_src, r_even_q, r_odd_q, r_font_qa, r_font_qb);
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_text_even[r_clr_row] <= 8'h00;
            r_text_odd[r_clr_row]  <= 8'h00;
        end else if (o_pop) begin
            if (i_q_cmd.even_we) begin
                r_text_even[i_q_cmd.even_row] <= i_q_cmd.even_wdata;
            end
            if (i_q_cmd.odd_we) begin
                r_text_odd[i_q_cmd.odd_row] <= i_q_cmd.odd_wdata;
            end
        end
        if (o_pop) begin
            r_even_q <= r_text_even[i_q_cmd.even_row];
            r_odd_q  <= r_text_odd[i_q_cmd.odd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_q_cmd.font_we) begin
                r_font[w_font_addr_a] <= i_q_cmd.font_wdata;
            end
            r_font_qa <= r_font[w_font_addr_a];
            r_font_qb <= r_font[w_font_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_cmd <= i_q_cmd;
        end
        if (w_s1_go) begin
            r_out_tdata <= {1'b0, r_s1_cmd.font_we, r_s1_cmd.display_flags,
                            r_s1_cmd.mark_b_bits, r_s1_cmd.mark_b_index,
                            r_s1_cmd.mark_a_bits, r_s1_cmd.mark_a_index, w_hi, w_lo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_row   <= '0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_go) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_clearing) begin
                r_clr_row <= r_clr_row + ROW_W'(1);
                if (r_clr_row == '1) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

endmodule

### sv/text_ram_cg_window_port.sv
// Top level of the text-RAM and character-generator window port.
// Holds the configuration registers and joins front end, queue and back end.
// Depends on txtcg_pkg, txtcg_front, txtcg_queue and txtcg_back.
//
// An access beat enters on the s_ channel: tdata carries the action, the byte offset
// and the write data. Each beat gives exactly one result beat on the m_ channel with
// the read data, two redraw marks, the display flags and the font-written flag.
// The access passes the queue, the memory stage and the output register in turn, and
// one access can be taken in every cycle while the receiver keeps up and no clearing pass runs;
// the text and font stores have a single-ported write and registered reads. A two-entry queue,
// a memory stage and an output register lie between the sides, so the input keeps flowing
// while the receiver stalls until the queue is full, and then s_tready falls.
// After reset the text store is cleared, one row of two bytes a cycle over all 8192 rows,
// with s_tready low; configuration writes are taken throughout. The font store holds
// whatever was last written to it. The APB registers are low_base (0x0), high_base (0x4),
// font write enable (0x8) and protect open (0xC); all reset to zero.
module text_ram_cg_window_port
    import txtcg_pkg::*;
#(
    parameter int FONT_ADDR_BITS = FONT_ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // action[1:0], address[16:2], write_data[32:17], zero fill
    input  logic [IN_W-1:0]    s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // read_data[15:0], mark_a_index[27:16], mark_a_bits[29:28], mark_b_index[41:30],
    // mark_b_bits[43:42], display_flags[45:44], font_written[46], zero fill
    output logic [OUT_W-1:0]   m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [BASE_W-1:0] r_low_base;
    logic [BASE_W-1:0] r_high_base;
    logic              r_font_we;
    logic              r_protect_open;

    logic               w_cfg_wr;
    t_reg               w_reg;
    logic               w_clearing;
    logic               w_q_full;
    logic               w_q_valid;
    logic [Q_CNT_W-1:0] w_q_count;
    logic               w_push;
    logic               w_pop;
    t_cmd               w_front_cmd;
    t_cmd               w_q_cmd;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = t_reg'(paddr[3:2]);

    always_comb begin
        unique case (w_reg)
            REG_LOW_BASE:     prdata = PDATA_W'(r_low_base);
            REG_HIGH_BASE:    prdata = PDATA_W'(r_high_base);
            REG_FONT_WE:      prdata = PDATA_W'(r_font_we);
            REG_PROTECT_OPEN: prdata = PDATA_W'(r_protect_open);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_base     <= '0;
            r_high_base    <= '0;
            r_font_we      <= 1'b0;
            r_protect_open <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_LOW_BASE:     r_low_base     <= pwdata[BASE_W-1:0];
                REG_HIGH_BASE:    r_high_base    <= pwdata[BASE_W-1:0];
                REG_FONT_WE:      r_font_we      <= pwdata[0];
                REG_PROTECT_OPEN: r_protect_open <= pwdata[0];
                default:          r_font_we      <= r_font_we;
            endcase
        end
    end

    txtcg_front u_front (
        .i_s_tvalid     (s_tvalid),
        .o_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_clearing     (w_clearing),
        .i_q_full       (w_q_full),
        .i_font_we      (r_font_we),
        .i_protect_open (r_protect_open),
        .o_push         (w_push),
        .o_cmd          (w_front_cmd)
    );

    txtcg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_count (w_q_count),
        .o_cmd   (w_q_cmd)
    );

    txtcg_back #(
        .FONT_ADDR_BITS (FONT_ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_pop       (w_pop),
        .i_low_base  (r_low_base),
        .i_high_base (r_high_base),
        .o_clearing  (w_clearing),
        .o_tvalid    (m_tvalid),
        .i_tready    (m_tready),
        .o_tdata     (m_tdata)
    );

    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_clearing |-> !s_tready
    ) else $error("access beat taken during the clearing pass");

    a_clear_ends_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_clearing) |-> (w_q_count == '0) && !m_tvalid
    ) else $error("work in flight when the clearing pass ended");

    a_queue_count: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> w_q_count == Q_CNT_W'($past(w_q_count) + 1'b1)
    ) else $error("queue count lost a pushed command");

    a_no_pop_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_pop |-> w_q_count != '0
    ) else $error("command popped from an empty queue");

endmodule

### dv/tb_text_ram_cg_window_port.sv
// Self-checking testbench for text_ram_cg_window_port: byte and word accesses across the
// code, attribute and font window areas, with random pacing on both stream sides.
// Depends on txtcg_pkg and text_ram_cg_window_port.
module tb_text_ram_cg_window_port
    import txtcg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          PHASES      = 6;
    localparam int          RANDOM_BEATS = 205;

    typedef struct packed {
        logic              font_written;
        logic [1:0]        display_flags;
        logic [1:0]        mark_b_bits;
        logic [CELL_W-1:0] mark_b_index;
        logic [1:0]        mark_a_bits;
        logic [CELL_W-1:0] mark_a_index;
        logic [DATA_W-1:0] read_data;
    } t_reply;

    class window_reply_board;
        logic [7:0]        text_mem [TEXT_BYTES];
        logic [7:0]        font_mem [int unsigned];
        logic [BASE_W-1:0] low_base;
        logic [BASE_W-1:0] high_base;
        bit                font_we;
        bit                prot_open;
        bit                blank_hit;
        t_reply            replies_due [$];
        int unsigned       failures;

        function new();
            foreach (text_mem[i]) text_mem[i] = 8'h00;
            low_base  = '0;
            high_base = '0;
            font_we   = 1'b0;
            prot_open = 1'b0;
            failures  = 0;
        endfunction

        function void set_reg(t_reg idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_LOW_BASE:  low_base  = value[BASE_W-1:0];
                REG_HIGH_BASE: high_base = value[BASE_W-1:0];
                REG_FONT_WE:   font_we   = value[0];
                default:       prot_open = value[0];
            endcase
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function logic [7:0] font_at(logic [BASE_W-1:0] base, logic [3:0] off);
            logic [BASE_W-1:0] idx;
            idx = base + BASE_W'(off);
            if (!font_mem.exists(int'(idx))) begin
                blank_hit = 1'b1;
                return 8'h00;
            end
            return font_mem[int'(idx)];
        endfunction

        function bit attr_open(logic [ADDR_W-1:0] a);
            return (a < PROT_START) || !a[1] || prot_open;
        endfunction

        function logic [DATA_W-1:0] read_value(t_action act, logic [ADDR_W-1:0] a);
            logic [3:0] off;
            off = a[4:1];
            if (act == ACT_READ_BYTE) begin
                if (a < FONT_START) return {8'h00, text_mem[a[13:0]]};
                if (a < WIN_END) return {8'h00, font_at(a[0] ? high_base : low_base, off)};
                return '0;
            end
            if (act == ACT_READ_WORD) begin
                if (a < ATTR_LAST) return {text_mem[a[13:0] + 14'd1], text_mem[a[13:0]]};
                if (a == ATTR_LAST) return {font_at(low_base, 4'd0), text_mem[a[13:0]]};
                if (a < FONT_LAST) begin
                    if (a[0]) return {font_at(low_base, off + 4'd1), font_at(high_base, off)};
                    return {font_at(high_base, off), font_at(low_base, off)};
                end
                if (a == FONT_LAST) return {8'h00, font_at(high_base, 4'd15)};
            end
            return '0;
        endfunction

        // True when a read would touch a font byte that has never been loaded.
        function bit touches_blank_font(t_action act, logic [ADDR_W-1:0] a);
            blank_hit = 1'b0;
            void'(read_value(act, a));
            return blank_hit;
        endfunction

        function void note_access(t_action act, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
            t_reply            r;
            logic [ADDR_W-1:0] t;
            logic [DATA_W-1:0] v;
            logic [BASE_W-1:0] fidx;
            r    = '0;
            fidx = high_base + BASE_W'(a[4:1]);
            case (act)
                ACT_READ_BYTE, ACT_READ_WORD: begin
                    r.read_data = read_value(act, a);
                end
                ACT_WRITE_BYTE: begin
                    if (a < ATTR_START) begin
                        text_mem[a[13:0]] = d[7:0];
                        r.mark_a_index  = a[12:1];
                        r.mark_a_bits   = MARK_CODE;
                        r.display_flags = DISP_CODE;
                    end else if (a < FONT_START) begin
                        if (!a[0] && attr_open(a)) begin
                            text_mem[a[13:0]] = d[7:0];
                            r.mark_a_index  = a[12:1];
                            r.mark_a_bits   = MARK_BOTH;
                            r.display_flags = DISP_CODE;
                        end
                    end else if (a < WIN_END) begin
                        if (a[0] && font_we) begin
                            font_mem[int'(fidx)] = d[7:0];
                            r.font_written = 1'b1;
                        end
                    end
                end
                default: begin
                    if (a <= CODE_SEAM) begin
                        text_mem[a[13:0]]         = d[7:0];
                        text_mem[a[13:0] + 14'd1] = d[15:8];
                        r.mark_a_index  = a[12:1];
                        r.mark_a_bits   = MARK_CODE;
                        r.display_flags = DISP_CODE;
                        if (a == CODE_SEAM) begin
                            r.mark_b_index = '0;
                            r.mark_b_bits  = MARK_BOTH;
                        end else if (a[0]) begin
                            t = a + 1'b1;
                            r.mark_b_index = t[12:1];
                            r.mark_b_bits  = MARK_CODE;
                        end
                    end else if (a < ATTR_LAST) begin
                        t = a;
                        v = d;
                        if (a[0]) begin
                            t = a + 1'b1;
                            v = d >> 8;
                        end
                        if (attr_open(t)) begin
                            text_mem[t[13:0]] = v[7:0];
                            r.mark_a_index  = t[12:1];
                            r.mark_a_bits   = MARK_BOTH;
                            r.display_flags = DISP_ATTR_WORD;
                        end
                    end else if (a < WIN_END) begin
                        v = a[0] ? d : (d >> 8);
                        if (font_we) begin
                            font_mem[int'(fidx)] = v[7:0];
                            r.font_written = 1'b1;
                        end
                    end
                end
            endcase
            replies_due.push_back(r);
        endfunction

        function void compare(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                failures++;
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_reply(logic [OUT_W-1:0] beat);
            t_reply got;
            t_reply want;
            got = beat[$bits(t_reply)-1:0];
            if (replies_due.size() == 0) begin
                failures++;
                $display("%0t: result beat expected none, got %h", $time, beat);
                return;
            end
            want = replies_due.pop_front();
            compare("read_data", want.read_data, got.read_data);
            compare("mark_a_index", want.mark_a_index, got.mark_a_index);
            compare("mark_a_bits", want.mark_a_bits, got.mark_a_bits);
            compare("mark_b_index", want.mark_b_index, got.mark_b_index);
            compare("mark_b_bits", want.mark_b_bits, got.mark_b_bits);
            compare("display_flags", want.display_flags, got.display_flags);
            compare("font_written", want.font_written, got.font_written);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    window_reply_board board;
    int unsigned       cycle_count = 0;
    int unsigned       burst_left  = 0;
    bit                valid_up    = 1'b0;
    int unsigned       stall_run   = 0;
    int unsigned       stall_mode  = 0;

    text_ram_cg_window_port i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            board.check_reply(m_tdata);
        end
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(16, 160);
        end
        stall_run--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((stall_run % 8) < 2);
        endcase
    end

    task automatic drop_valid();
        if (valid_up) begin
            s_tvalid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    task automatic send_access(input t_action act, input logic [ADDR_W-1:0] a,
                               input logic [DATA_W-1:0] d);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                drop_valid();
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W-33){1'b0}}, d, a, act};
        valid_up = 1'b1;
        do @(posedge i_clk); while (s_tready !== 1'b1);
        board.note_access(act, a, d);
    endtask

    task automatic write_reg(input t_reg idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    // Loads all sixteen font bytes of the current high half row.
    task automatic fill_font_rows();
        for (int k = 0; k < 16; k++) begin
            send_access(ACT_WRITE_BYTE, FONT_START + ADDR_W'(2 * k + 1), DATA_W'($urandom));
        end
    endtask

    task automatic run_directed();
        send_access(ACT_WRITE_WORD, 15'h0000, 16'hFFFF);
        send_access(ACT_READ_WORD,  15'h0000, 16'h0000);
        send_access(ACT_WRITE_WORD, 15'h1FFF, 16'hA55A);
        send_access(ACT_READ_WORD,  15'h1FFE, 16'hFFFF);
        send_access(ACT_READ_BYTE,  15'h2000, 16'h0000);
        send_access(ACT_WRITE_WORD, 15'h0011, 16'h1234);
        send_access(ACT_WRITE_BYTE, 15'h2001, 16'h00FF);
        send_access(ACT_WRITE_BYTE, 15'h2002, 16'h0077);
        send_access(ACT_WRITE_WORD, 15'h2003, 16'hBEEF);
        send_access(ACT_WRITE_WORD, 15'h3FE2, 16'h1111);
        send_access(ACT_WRITE_WORD, 15'h3FE0, 16'h2222);
        send_access(ACT_WRITE_BYTE, 15'h3FFE, 16'h0033);
        send_access(ACT_WRITE_BYTE, 15'h3FFC, 16'h0044);
        send_access(ACT_READ_WORD,  15'h3FFC, 16'h0000);
        send_access(ACT_WRITE_WORD, 15'h3FFF, 16'hC0DE);
        send_access(ACT_WRITE_BYTE, 15'h4000, 16'h00AA);
        send_access(ACT_WRITE_WORD, 15'h4FFE, 16'h5A00);
        send_access(ACT_READ_WORD,  15'h3FFF, 16'h0000);
        send_access(ACT_READ_WORD,  15'h4FFF, 16'h0000);
        send_access(ACT_READ_WORD,  15'h4001, 16'h0000);
        send_access(ACT_READ_WORD,  15'h4FFD, 16'h0000);
        send_access(ACT_READ_BYTE,  15'h4003, 16'h0000);
        send_access(ACT_READ_BYTE,  15'h4002, 16'h0000);
        send_access(ACT_READ_BYTE,  15'h5000, 16'h0000);
        send_access(ACT_READ_WORD,  15'h7FFF, 16'hFFFF);
        send_access(ACT_WRITE_WORD, 15'h7FFE, 16'hFFFF);
    endtask

    function automatic logic [ADDR_W-1:0] pick_address(logic [ADDR_W-1:0] hot);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) return hot + ADDR_W'($urandom_range(0, 63));
        if (pick < 45) return ADDR_W'($urandom_range(0, 16'h1FFF));
        if (pick < 55) return ADDR_W'($urandom_range(16'h2000, 16'h3FFF));
        if (pick < 65) return PROT_START + ADDR_W'($urandom_range(0, 31));
        if (pick < 88) return ADDR_W'($urandom_range(16'h4000, 16'h4FFF));
        if (pick < 94) begin
            case ($urandom_range(0, 9))
                0:       return CODE_SEAM - 1'b1;
                1:       return CODE_SEAM;
                2:       return ATTR_START;
                3:       return PROT_START - 1'b1;
                4:       return ATTR_LAST - 1'b1;
                5:       return ATTR_LAST;
                6:       return FONT_START;
                7:       return FONT_LAST - 1'b1;
                8:       return FONT_LAST;
                default: return WIN_END;
            endcase
        end
        return ADDR_W'($urandom_range(16'h5000, 16'h7FFF));
    endfunction

    task automatic send_random(input logic [ADDR_W-1:0] hot);
        t_action           act;
        logic [ADDR_W-1:0] a;
        act = t_action'($urandom_range(0, 3));
        a   = pick_address(hot);
        if (board.touches_blank_font(act, a)) a = {2'b00, a[12:0]};
        send_access(act, a, DATA_W'($urandom));
    endtask

    initial begin
        logic [BASE_W-1:0] spot_a;
        logic [BASE_W-1:0] spot_b;
        logic [BASE_W-1:0] lo;
        logic [BASE_W-1:0] hi;
        bit                we;
        bit                op;
        logic [ADDR_W-1:0] hot;
        board = new();
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        spot_a = BASE_W'($urandom);
        spot_b = BASE_W'($urandom);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin lo = '0;        hi = '0;          we = 1'b1; op = 1'b0; end
                1:       begin lo = 19'h7FFFF; hi = 19'h7FFF8;   we = 1'b1; op = 1'b1; end
                2:       begin lo = spot_a;    hi = spot_a;      we = 1'b1; op = 1'b0; end
                3:       begin lo = spot_a;    hi = 19'h7FFF8;   we = 1'b0; op = 1'b1; end
                4:       begin lo = spot_a;    hi = spot_b;      we = 1'b1; op = 1'b1; end
                default: begin lo = '0;        hi = 19'h7FFFF;   we = 1'b0; op = 1'b0; end
            endcase
            write_reg(REG_LOW_BASE, PDATA_W'(lo));
            write_reg(REG_HIGH_BASE, PDATA_W'(hi));
            write_reg(REG_FONT_WE, PDATA_W'(we));
            write_reg(REG_PROTECT_OPEN, PDATA_W'(op));
            if (we) fill_font_rows();
            if (p == 0) run_directed();
            hot = ADDR_W'($urandom_range(0, 16'h3FC0));
            repeat (RANDOM_BEATS) send_random(hot);
            drop_valid();
            while (board.pending() != 0) @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### text_ram_cg_window_port.f
sv/txtcg_pkg.sv
sv/txtcg_front.sv
sv/txtcg_queue.sv
sv/txtcg_back.sv
sv/text_ram_cg_window_port.sv
dv/tb_text_ram_cg_window_port.sv
